FILE: rtl/heading_dead_reckoning_macros.svh
// Assertion macros shared by the heading dead-reckoning checker.
`ifndef HEADING_DEAD_RECKONING_MACROS_SVH
`define HEADING_DEAD_RECKONING_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define HDR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("heading_dead_reckoning: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define HDR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error("heading_dead_reckoning: next-cycle check failed");

`endif

FILE: rtl/hdr_pkg.sv
// Package with the constants, types and tables of the heading dead-reckoning block.
package hdr_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int POS_WIDTH    = 48;
  localparam int ARC_LEN      = 24;
  localparam int NSTEPS       = (CORDIC_STEPS < ARC_LEN) ? CORDIC_STEPS : ARC_LEN;
  localparam int STEP_W       = $clog2(NSTEPS);
  localparam int PW1          = POS_WIDTH + 1;
  localparam int EXT_W        = 64;

  localparam int ACT_W   = 2;
  localparam int QUAT_W  = 16;
  localparam int MOVE_W  = 8;
  localparam int SCALE_W = 16;
  localparam int OUT_W   = 48;
  localparam int HEAD_W  = 16;

  // Shared multiplier: 25 x 17 signed.
  localparam int MA_W = 25;
  localparam int MB_W = 17;
  localparam int MP_W = MA_W + MB_W;

  // Accumulator and CORDIC datapath width, and the CORDIC angle width.
  localparam int CW = 44;
  localparam int ZW = 34;

  localparam logic [SCALE_W-1:0]       SCALE_RESET = 16'd655;
  localparam logic signed [HEAD_W-1:0] COS_RESET   = 16'sd32767;
  localparam logic signed [CW-1:0]     GAIN_Q30    = CW'(652032874);
  localparam logic signed [CW-1:0]     ROUND_Q15   = CW'(16384);
  localparam logic signed [CW-1:0]     ACC_Q15_MAX = CW'(32767);
  localparam logic signed [CW-1:0]     ACC_Q15_MIN = -CW'(32768);
  localparam logic signed [ZW-1:0]     Z_QUARTER   = ZW'(64'h4000_0000);
  localparam logic signed [ZW-1:0]     Z_HALF      = ZW'(64'h8000_0000);
  localparam logic [31:0]              HEAD_ROUND  = 32'h0000_8000;

  localparam logic [2:0] MUL_LAST = 3'd6;

  typedef enum logic [ACT_W-1:0] {
    ACT_ORIENT = 2'd0,
    ACT_MOVE   = 2'd1,
    ACT_CLEAR  = 2'd2
  } hdr_action_e;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b0_0000_0001,
    ST_MUL  = 9'b0_0000_0010,
    ST_VSET = 9'b0_0000_0100,
    ST_VEC  = 9'b0_0000_1000,
    ST_RSET = 9'b0_0001_0000,
    ST_ROT  = 9'b0_0010_0000,
    ST_TRIG = 9'b0_0100_0000,
    ST_UPD  = 9'b0_1000_0000,
    ST_DONE = 9'b1_0000_0000
  } hdr_state_e;

  // Arctangent of 2^-n as a 32-bit binary angle (2^32 is a full turn), truncated.
  function automatic logic [31:0] arc_tan(input logic [4:0] n);
    logic [31:0] r;
    case (n)
      5'd0:    r = 32'h2000_0000;
      5'd1:    r = 32'h12E4_051E;
      5'd2:    r = 32'h09FB_385B;
      5'd3:    r = 32'h0511_11D4;
      5'd4:    r = 32'h028B_0D43;
      5'd5:    r = 32'h0145_D7E1;
      5'd6:    r = 32'h00A2_F61E;
      5'd7:    r = 32'h0051_7C55;
      5'd8:    r = 32'h0028_BE53;
      5'd9:    r = 32'h0014_5F2F;
      5'd10:   r = 32'h000A_2F98;
      5'd11:   r = 32'h0005_17CC;
      5'd12:   r = 32'h0002_8BE6;
      5'd13:   r = 32'h0001_45F3;
      5'd14:   r = 32'h0000_A2F9;
      5'd15:   r = 32'h0000_517C;
      5'd16:   r = 32'h0000_28BE;
      5'd17:   r = 32'h0000_145F;
      5'd18:   r = 32'h0000_0A2F;
      5'd19:   r = 32'h0000_0517;
      5'd20:   r = 32'h0000_028B;
      5'd21:   r = 32'h0000_0145;
      5'd22:   r = 32'h0000_00A2;
      5'd23:   r = 32'h0000_0051;
      default: r = 32'h0000_0000;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/hdr_intf.sv
// Valid/ready channel interfaces for the input items and the result items.
interface hdr_item_if;
  import hdr_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [ACT_W-1:0]          action;
  logic signed [QUAT_W-1:0]  quat_real;
  logic signed [QUAT_W-1:0]  quat_i;
  logic signed [QUAT_W-1:0]  quat_j;
  logic signed [QUAT_W-1:0]  quat_k;
  logic signed [MOVE_W-1:0]  move_dx;
  logic signed [MOVE_W-1:0]  move_dy;

  modport source (
    output valid, action, quat_real, quat_i, quat_j, quat_k, move_dx, move_dy,
    input  ready
  );
  modport sink (
    input  valid, action, quat_real, quat_i, quat_j, quat_k, move_dx, move_dy,
    output ready
  );
endinterface

interface hdr_result_if;
  import hdr_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [OUT_W-1:0]   out_x;
  logic signed [OUT_W-1:0]   out_y;
  logic signed [HEAD_W-1:0]  out_heading;

  modport source (output valid, out_x, out_y, out_heading, input ready);
  modport sink (input valid, out_x, out_y, out_heading, output ready);
endinterface

FILE: rtl/heading_dead_reckoning.sv
// Top level of the heading dead-reckoning position tracker.
// This block keeps a heading and a saturating Q32.16 x/y position. An orientation item
// (action 0) carries a Q14 quaternion; its yaw atan2(2(ij+kr), i*i-j*j-k*k+r*r) is found
// with a vectoring CORDIC and stored as a 16-bit binary angle (32768 is pi), and a
// rotating CORDIC then derives the Q15 cosine and sine of that heading. A motion item
// (action 1) carries signed 8-bit displacement counts, which are scaled by the Q16
// reciprocal held in the configuration register (reset 655, about 1/100), rotated by the
// kept heading and added to the position with saturation. A clear item (action 2) zeroes
// the position, and code 3 changes nothing. Every item returns exactly one result item
// with the position and the heading. All arithmetic goes through one 25 x 17 signed
// multiplier with an accumulator and one CORDIC shift-add stage, run by a small
// sequencer, so the block takes one item at a time and drops in_i.ready while it works.
// With the default sixteen CORDIC steps an orientation item passes through the accept
// state, the multiplier, a setup step, two CORDIC passes of sixteen steps at one step
// per cycle, a step that stores the heading and one that rounds the cosine and sine,
// and the load of the output register before the next item can be accepted. A motion
// item passes through accept, the multiplier for its six products, the position
// update and the output load, and a clear item through accept and the output load.
// A finished result sits in the output register, and a new item is taken while it waits;
// the block only stalls when the next result is ready before the previous one has left.
module heading_dead_reckoning (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  hdr_item_if.sink                     in_i,
  hdr_result_if.source                 out_o,
  input  logic                         cfg_we_i,
  input  logic [hdr_pkg::SCALE_W-1:0]  cfg_wdata_i
);
  import hdr_pkg::*;

  // Sequencer state and counters.
  hdr_state_e        state_q, state_d;
  logic [2:0]        mcnt_q, mcnt_d;
  logic [STEP_W-1:0] n_q, n_d;

  // Architectural state.
  logic [SCALE_W-1:0]       scale_q;
  logic signed [HEAD_W-1:0] heading_q, heading_d;
  logic signed [HEAD_W-1:0] cos_q, cos_d;
  logic signed [HEAD_W-1:0] sin_q, sin_d;
  logic signed [POS_WIDTH-1:0] pos_x_q, pos_x_d;
  logic signed [POS_WIDTH-1:0] pos_y_q, pos_y_d;

  // Latched item.
  logic [ACT_W-1:0]         act_q, act_d;
  logic signed [QUAT_W-1:0] qr_q, qr_d, qi_q, qi_d, qj_q, qj_d, qk_q, qk_d;
  logic signed [MOVE_W-1:0] dx_q, dx_d, dy_q, dy_d;

  // Datapath registers.
  logic signed [MA_W-1:0] d_q, d_d, e_q, e_d;
  logic signed [MP_W-1:0] prod_q;
  logic signed [CW-1:0]   x_q, x_d, y_q, y_d;
  logic signed [ZW-1:0]   z_q, z_d;
  logic                   flip_q, flip_d;

  // Output register.
  logic                     out_valid_q, out_valid_d;
  logic signed [OUT_W-1:0]  out_x_q, out_x_d, out_y_q, out_y_d;
  logic signed [HEAD_W-1:0] out_head_q, out_head_d;

  // Combinational helpers.
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [MP_W-1:0] mul_p;
  logic signed [CW-1:0]   prod_ext;
  logic signed [CW-1:0]   tx, ty, y2, wx, wy;
  logic signed [ZW-1:0]   arc, zr;
  logic                   turn_neg;
  logic [31:0]            hz;
  logic signed [HEAD_W-1:0] head_new;
  logic signed [EXT_W-1:0]  px_ext, py_ext;
  logic                   step_last;

  // Rounds a Q30 value to Q15 (half up) and saturates it to 16 bits.
  function automatic logic signed [HEAD_W-1:0] q15_of(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] r;
    r = (v + ROUND_Q15) >>> 15;
    if (r > ACC_Q15_MAX) begin
      r = ACC_Q15_MAX;
    end else if (r < ACC_Q15_MIN) begin
      r = ACC_Q15_MIN;
    end
    return r[HEAD_W-1:0];
  endfunction

  // Adds a step to a coordinate and clamps it to the signed position range.
  function automatic logic signed [POS_WIDTH-1:0] sat_add(
    input logic signed [POS_WIDTH-1:0] p,
    input logic signed [CW-1:0]        w
  );
    logic signed [PW1-1:0] s;
    s = PW1'(p) + PW1'(w);
    if (s[PW1-1] != s[PW1-2]) begin
      return s[PW1-1] ? {1'b1, {(POS_WIDTH-1){1'b0}}} : {1'b0, {(POS_WIDTH-1){1'b1}}};
    end
    return s[POS_WIDTH-1:0];
  endfunction

  assign in_i.ready        = (state_q == ST_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.out_x       = out_x_q;
  assign out_o.out_y       = out_y_q;
  assign out_o.out_heading = out_head_q;

  // Operand selection for the shared multiplier. Orientation items form the six
  // quaternion products; motion items first scale the counts, then rotate them.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (act_q == ACT_MOVE) begin
      case (mcnt_q)
        3'd0: begin mul_a = MA_W'(dx_q); mul_b = {1'b0, scale_q}; end
        3'd1: begin mul_a = MA_W'(dy_q); mul_b = {1'b0, scale_q}; end
        3'd2: begin mul_a = d_q;         mul_b = MB_W'(cos_q);    end
        3'd3: begin mul_a = e_q;         mul_b = MB_W'(sin_q);    end
        3'd4: begin mul_a = d_q;         mul_b = MB_W'(sin_q);    end
        3'd5: begin mul_a = e_q;         mul_b = MB_W'(cos_q);    end
        default: begin mul_a = '0;       mul_b = '0;              end
      endcase
    end else begin
      case (mcnt_q)
        3'd0: begin mul_a = MA_W'(qi_q); mul_b = MB_W'(qj_q); end
        3'd1: begin mul_a = MA_W'(qk_q); mul_b = MB_W'(qr_q); end
        3'd2: begin mul_a = MA_W'(qi_q); mul_b = MB_W'(qi_q); end
        3'd3: begin mul_a = MA_W'(qj_q); mul_b = MB_W'(qj_q); end
        3'd4: begin mul_a = MA_W'(qk_q); mul_b = MB_W'(qk_q); end
        3'd5: begin mul_a = MA_W'(qr_q); mul_b = MB_W'(qr_q); end
        default: begin mul_a = '0;       mul_b = '0;          end
      endcase
    end
  end

  assign mul_p    = mul_a * mul_b;
  assign prod_ext = CW'(prod_q);

  // One CORDIC micro-rotation. Both modes share the stage: in the rotating pass the
  // sign of the residual angle picks the direction, in the vectoring pass the sign of y.
  assign tx        = x_q >>> n_q;
  assign ty        = y_q >>> n_q;
  assign arc       = ZW'(arc_tan(5'(n_q)));
  assign turn_neg  = (state_q == ST_ROT) ? !z_q[ZW-1] : (y_q[CW-1] || (y_q == '0));
  assign step_last = (n_q == STEP_W'(NSTEPS - 1));

  // Heading from the vectoring angle: rounded half up to 16 bits and wrapped.
  assign hz       = z_q[31:0] + HEAD_ROUND;
  assign head_new = hz[31:16];
  assign zr       = ZW'(head_new) <<< 16;

  assign y2 = y_q <<< 1;
  assign wx = (x_q + ROUND_Q15) >>> 15;
  assign wy = (y_q + ROUND_Q15) >>> 15;

  assign px_ext = EXT_W'(pos_x_q);
  assign py_ext = EXT_W'(pos_y_q);

  always_comb begin
    state_d     = state_q;
    mcnt_d      = mcnt_q;
    n_d         = n_q;
    heading_d   = heading_q;
    cos_d       = cos_q;
    sin_d       = sin_q;
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    act_d       = act_q;
    qr_d        = qr_q;
    qi_d        = qi_q;
    qj_d        = qj_q;
    qk_d        = qk_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    d_d         = d_q;
    e_d         = e_q;
    x_d         = x_q;
    y_d         = y_q;
    z_d         = z_q;
    flip_d      = flip_q;
    out_valid_d = out_valid_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_head_d  = out_head_q;

    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          act_d = in_i.action;
          qr_d  = in_i.quat_real;
          qi_d  = in_i.quat_i;
          qj_d  = in_i.quat_j;
          qk_d  = in_i.quat_k;
          dx_d  = in_i.move_dx;
          dy_d  = in_i.move_dy;
          case (in_i.action)
            ACT_ORIENT, ACT_MOVE: begin
              state_d = ST_MUL;
              mcnt_d  = '0;
              x_d     = '0;
              y_d     = '0;
            end
            ACT_CLEAR: begin
              pos_x_d = '0;
              pos_y_d = '0;
              state_d = ST_DONE;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      // The product of the previous count is accumulated while the next one forms.
      ST_MUL: begin
        if (act_q == ACT_MOVE) begin
          case (mcnt_q) inside
            3'd1:       d_d = prod_q[MA_W-1:0];
            3'd2:       e_d = prod_q[MA_W-1:0];
            3'd3:       x_d = x_q + prod_ext;
            3'd4:       x_d = x_q - prod_ext;
            3'd5, 3'd6: y_d = y_q + prod_ext;
            default:    ;
          endcase
        end else begin
          case (mcnt_q) inside
            3'd1, 3'd2: y_d = y_q + prod_ext;
            3'd3, 3'd6: x_d = x_q + prod_ext;
            3'd4, 3'd5: x_d = x_q - prod_ext;
            default:    ;
          endcase
        end
        if (mcnt_q == MUL_LAST) begin
          state_d = (act_q == ACT_MOVE) ? ST_UPD : ST_VSET;
        end else begin
          mcnt_d = mcnt_q + 3'd1;
        end
      end

      // A zero vector gives heading zero; a vector in the left half plane is turned by pi.
      ST_VSET: begin
        n_d = '0;
        if ((x_q == '0) && (y2 == '0)) begin
          z_d     = '0;
          state_d = ST_RSET;
        end else if (x_q[CW-1]) begin
          x_d     = -x_q;
          y_d     = -y2;
          z_d     = Z_HALF;
          state_d = ST_VEC;
        end else begin
          y_d     = y2;
          z_d     = '0;
          state_d = ST_VEC;
        end
      end

      ST_VEC, ST_ROT: begin
        if (turn_neg) begin
          x_d = x_q - ty;
          y_d = y_q + tx;
          z_d = z_q - arc;
        end else begin
          x_d = x_q + ty;
          y_d = y_q - tx;
          z_d = z_q + arc;
        end
        if (step_last) begin
          state_d = (state_q == ST_VEC) ? ST_RSET : ST_TRIG;
        end else begin
          n_d = n_q + STEP_W'(1);
        end
      end

      // Store the heading and fold its angle into the right half plane for rotation.
      ST_RSET: begin
        heading_d = head_new;
        n_d       = '0;
        x_d       = GAIN_Q30;
        y_d       = '0;
        if (zr > Z_QUARTER) begin
          z_d    = zr - Z_HALF;
          flip_d = 1'b1;
        end else if (zr < -Z_QUARTER) begin
          z_d    = zr + Z_HALF;
          flip_d = 1'b1;
        end else begin
          z_d    = zr;
          flip_d = 1'b0;
        end
        state_d = ST_ROT;
      end

      ST_TRIG: begin
        cos_d   = q15_of(flip_q ? -x_q : x_q);
        sin_d   = q15_of(flip_q ? -y_q : y_q);
        state_d = ST_DONE;
      end

      ST_UPD: begin
        pos_x_d = sat_add(pos_x_q, wx);
        pos_y_d = sat_add(pos_y_q, wy);
        state_d = ST_DONE;
      end

      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_x_d     = px_ext[OUT_W-1:0];
          out_y_d     = py_ext[OUT_W-1:0];
          out_head_d  = heading_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mcnt_q      <= '0;
      n_q         <= '0;
      out_valid_q <= 1'b0;
      scale_q     <= SCALE_RESET;
      heading_q   <= '0;
      cos_q       <= COS_RESET;
      sin_q       <= '0;
      pos_x_q     <= '0;
      pos_y_q     <= '0;
    end else begin
      state_q     <= state_d;
      mcnt_q      <= mcnt_d;
      n_q         <= n_d;
      out_valid_q <= out_valid_d;
      heading_q   <= heading_d;
      cos_q       <= cos_d;
      sin_q       <= sin_d;
      pos_x_q     <= pos_x_d;
      pos_y_q     <= pos_y_d;
      if (cfg_we_i) begin
        scale_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    qr_q       <= qr_d;
    qi_q       <= qi_d;
    qj_q       <= qj_d;
    qk_q       <= qk_d;
    dx_q       <= dx_d;
    dy_q       <= dy_d;
    d_q        <= d_d;
    e_q        <= e_d;
    prod_q     <= mul_p;
    x_q        <= x_d;
    y_q        <= y_d;
    z_q        <= z_d;
    flip_q     <= flip_d;
    out_x_q    <= out_x_d;
    out_y_q    <= out_y_d;
    out_head_q <= out_head_d;
  end

endmodule

FILE: rtl/hdr_checker.sv
// Port-level assertion checker for the heading dead-reckoning block, with its bind.
`include "heading_dead_reckoning_macros.svh"

module hdr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic [hdr_pkg::ACT_W-1:0]   in_action_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [hdr_pkg::HEAD_W-1:0]  out_heading_i
);
  import hdr_pkg::*;

  logic in_acc;
  logic orient_acc;
  logic out_stall;

  assign in_acc     = in_valid_i && in_ready_i;
  assign orient_acc = in_acc && (in_action_i == ACT_ORIENT);
  assign out_stall  = out_valid_i && !out_ready_i;

  // The block works on one item at a time.
  `HDR_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_acc, !in_ready_i)

  // A new result appears only at the end of a busy period.
  `HDR_ASSERT_NOW(a_result_after_work, clk_i, rst_ni, $rose(out_valid_i), $past(!in_ready_i))

  // An orientation item keeps the block busy while it is still in the multiplier.
  `HDR_ASSERT_NOW(a_orient_busy, clk_i, rst_ni, orient_acc, ##4 !in_ready_i)

  // A stalled result keeps its heading.
  `HDR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_i && $stable(out_heading_i))

endmodule

bind heading_dead_reckoning hdr_checker u_hdr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_action_i   (in_i.action),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_heading_i (out_o.out_heading)
);
